// ===== hw/rtl/ekwc_pkg.sv =====
// ----------------------------------------------------------------------------
// ekwc_pkg
// Shared types and constants for the eased keyframe width curve.
// ----------------------------------------------------------------------------
package ekwc_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned FRAC_W  = 16;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EASE,
        ST_MUL,
        ST_OUT
    } t_state;

    // Broadcast from the controller to every cell in the row.
    typedef struct packed {
        logic                     ins;
        logic                     clr;
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] wid;
    } t_cell_cmd;

endpackage

// ===== hw/rtl/ekwc_cell.sv =====
// ----------------------------------------------------------------------------
// ekwc_cell
// One keyframe slot. Slots shift toward the tail on insert, so the row stays
// sorted by position with equal positions kept in arrival order.
// ----------------------------------------------------------------------------
module ekwc_cell
    import ekwc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_cmd                i_cmd,
    input  logic                     i_prev_valid,
    input  logic                     i_prev_gt,
    input  logic signed [DATA_W-1:0] i_prev_pos,
    input  logic signed [DATA_W-1:0] i_prev_wid,
    output logic                     o_valid,
    output logic                     o_gt,
    output logic signed [DATA_W-1:0] o_pos,
    output logic signed [DATA_W-1:0] o_wid
);

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_pos;
    logic signed [DATA_W-1:0] r_wid;

    // This slot's key lies strictly after the new key (or slot is empty).
    assign o_gt    = !r_valid || (r_pos > i_cmd.pos);
    assign o_valid = r_valid;
    assign o_pos   = r_pos;
    assign o_wid   = r_wid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ins && o_gt) begin
            r_valid <= r_valid || i_prev_valid || !i_prev_gt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && o_gt) begin
            if (i_prev_gt) begin
                r_pos <= i_prev_pos;
                r_wid <= i_prev_wid;
            end else begin
                r_pos <= i_cmd.pos;
                r_wid <= i_cmd.wid;
            end
        end
    end

endmodule

// ===== hw/rtl/ekwc_divider.sv =====
// ----------------------------------------------------------------------------
// ekwc_divider
// Restoring divider, one quotient bit per cycle, for the Q0.16 fraction.
// ----------------------------------------------------------------------------
module ekwc_divider
    import ekwc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_start,
    input  logic [DATA_W:0]     i_num,
    input  logic [DATA_W:0]     i_den,
    output logic                o_done,
    output logic [FRAC_W-1:0]   o_quot
);

    logic [DATA_W+1:0] r_rem;
    logic [DATA_W:0]   r_den;
    logic [FRAC_W-1:0] r_quot;
    logic [4:0]        r_cnt;
    logic [DATA_W+1:0] w_try;
    logic [DATA_W+1:0] w_sh;

    // Since num < den, the quotient of num*2^16/den fits in 16 bits.
    assign w_sh   = {r_rem[DATA_W:0], 1'b0};
    assign w_try  = w_sh - {1'b0, r_den};
    assign o_done = (r_cnt == 5'(FRAC_W));
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
            r_cnt  <= '0;
        end else if (!o_done) begin
            r_rem  <= w_try[DATA_W+1] ? w_sh : w_try;
            r_quot <= {r_quot[FRAC_W-2:0], !w_try[DATA_W+1]};
            r_cnt  <= r_cnt + 5'd1;
        end
    end

endmodule

// ===== hw/rtl/eased_keyframe_width_curve_top.sv =====
// ----------------------------------------------------------------------------
// eased_keyframe_width_curve_top
// Sorted keyframe table with eased linear interpolation between keys.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries a mode (insert, clear or query), a
// position and a key width. Every input transfer produces exactly one output
// transfer with the query width, the largest stored width, the key count and
// a drop flag for an insert into a full table.
// The table is a row of MAX_KEYS cells; an insert shifts the tail of the row
// by one slot, all cells moving together, so an insert, a clear or an unused
// mode has its result valid in the cycle right after the input transfer. A
// query that needs a blend first latches the bracketing keys, then starts the
// divider, which yields the fraction one bit per cycle, and after the divider
// is done the ease square and the blend multiply take one stage each. A query
// on an empty table, before the first key or at or past the last key skips
// the divider. One item is in flight at a time; a new input transfer is taken
// in the cycle after the previous result transfer. The divider sets the
// query rate. Reset empties the table and the maximum width. While the
// receiver stalls, the result holds steady and no new item is accepted.
// ----------------------------------------------------------------------------
module eased_keyframe_width_curve_top
    import ekwc_pkg::*;
#(
    parameter int unsigned MAX_KEYS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_mode,
    input  logic signed [DATA_W-1:0]  i_position,
    input  logic signed [DATA_W-1:0]  i_key_width,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [DATA_W-1:0]  o_width_out,
    output logic signed [DATA_W-1:0]  o_max_width,
    output logic [COUNT_W-1:0]        o_entry_count,
    output logic                      o_dropped
);

    localparam int unsigned CNT_W = $clog2(MAX_KEYS + 1);

    t_state r_state, n_state;
    t_cell_cmd w_cmd;

    logic [MAX_KEYS-1:0]             w_valid;
    logic [MAX_KEYS-1:0]             w_gt;
    logic signed [DATA_W-1:0]        w_pos [MAX_KEYS];
    logic signed [DATA_W-1:0]        w_wid [MAX_KEYS];

    logic [CNT_W-1:0]                r_count;
    logic signed [DATA_W-1:0]        r_widest;
    logic signed [DATA_W-1:0]        r_q;
    logic signed [DATA_W-1:0]        r_wa, r_wb;
    logic signed [DATA_W-1:0]        r_res;
    logic                            r_drop;
    logic [2*FRAC_W+1:0]             r_ease;
    logic                            w_accept;
    logic                            w_full;
    logic                            w_div_done;
    logic [FRAC_W-1:0]               w_frac;
    logic [DATA_W:0]                 r_num, r_den;

    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count >= CNT_W'(MAX_KEYS));
    assign w_cmd = '{
        ins: w_accept && (t_mode'(i_mode) == MODE_INSERT) && !w_full,
        clr: w_accept && (t_mode'(i_mode) == MODE_CLEAR),
        pos: i_position,
        wid: i_key_width
    };

    // Row of keyframe cells; cell 0 sees an empty predecessor that is never greater.
    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        if (g == 0) begin : g_head
            ekwc_cell u_cell (
                .i_clk, .i_rst_n, .i_cmd(w_cmd),
                .i_prev_valid(1'b0), .i_prev_gt(1'b0),
                .i_prev_pos(i_position), .i_prev_wid(i_key_width),
                .o_valid(w_valid[g]), .o_gt(w_gt[g]),
                .o_pos(w_pos[g]), .o_wid(w_wid[g])
            );
        end else begin : g_body
            ekwc_cell u_cell (
                .i_clk, .i_rst_n, .i_cmd(w_cmd),
                .i_prev_valid(w_valid[g-1]), .i_prev_gt(w_gt[g-1]),
                .i_prev_pos(w_pos[g-1]), .i_prev_wid(w_wid[g-1]),
                .o_valid(w_valid[g]), .o_gt(w_gt[g]),
                .o_pos(w_pos[g]), .o_wid(w_wid[g])
            );
        end
    end

    // Bracket search: first valid cell whose position exceeds the query.
    // Valid cells form a prefix, so the strict-greater flags form a suffix.
    // When the first such cell is cell 0 the answer is trivial and the lower
    // bracket is not used.
    logic [MAX_KEYS-1:0]      w_above;
    logic [MAX_KEYS-1:0]      w_first;
    logic                     w_any;
    logic signed [DATA_W-1:0] w_p0, w_p1, w_w0, w_w1, w_wlast;
    always_comb begin
        for (int k = 0; k < MAX_KEYS; k++) begin
            w_above[k] = w_valid[k] && (w_pos[k] > r_q);
        end
        w_first = w_above & ~(w_above << 1);
        w_any   = |w_above;
        w_p0 = '0; w_p1 = '0; w_w0 = '0; w_w1 = '0; w_wlast = '0;
        for (int k = 0; k < MAX_KEYS; k++) begin
            if (w_first[k]) begin
                w_p1 = w_pos[k];
                w_w1 = w_wid[k];
            end
            if (w_valid[k]) begin
                w_wlast = w_wid[k];
            end
        end
        for (int k = 1; k < MAX_KEYS; k++) begin
            if (w_first[k]) begin
                w_p0 = w_pos[k-1];
                w_w0 = w_wid[k-1];
            end
        end
    end

    // Query sequencing: in the cycle after accept the bracket is latched, then the
    // divider is started from it; on a trivial answer the divider is skipped.
    logic r_start_d;
    logic r_trivial;
    logic r_bsel;
    logic [2:0] r_wait;

    ekwc_divider u_div (
        .i_clk, .i_start(r_start_d),
        .i_num(r_num), .i_den(r_den),
        .o_done(w_div_done), .o_quot(w_frac)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_start_d <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_start_d <= (r_state == ST_DIV) && !r_bsel;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = (t_mode'(i_mode) == MODE_QUERY) ? ST_DIV : ST_OUT;
            ST_DIV:  if (r_bsel && r_trivial) n_state = ST_OUT;
                     else if (r_bsel && r_wait[2] && w_div_done) n_state = ST_EASE;
            ST_EASE: n_state = ST_MUL;
            ST_MUL:  n_state = ST_OUT;
            ST_OUT:  if (!i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Ease: quadratic ease-in-out on the Q0.16 fraction.
    logic [FRAC_W:0]     w_u;
    logic [2*FRAC_W+1:0] w_sq;
    assign w_u  = {w_frac, 1'b0} - {1'b1, {FRAC_W{1'b0}}};
    assign w_sq = w_frac[FRAC_W-1] ? (2*FRAC_W+2)'(w_u) * (2*FRAC_W+2)'(w_u)
                                   : (2*FRAC_W+2)'(w_frac) * (2*FRAC_W+2)'(w_frac);

    logic signed [DATA_W+1:0]     w_d;
    logic signed [DATA_W+FRAC_W+2:0] w_prod;
    logic [FRAC_W:0]              w_e;
    assign w_e = w_frac[FRAC_W-1]
        ? (FRAC_W+1)'(((2*FRAC_W+2)'(1) << 32) + ((2*FRAC_W+2)'(w_u) << 17) - r_ease >> 17)
        : (FRAC_W+1)'(r_ease >> 15);
    assign w_d    = (DATA_W+2)'(r_wb) - (DATA_W+2)'(r_wa);
    assign w_prod = (DATA_W+FRAC_W+3)'(w_d) * $signed({1'b0, w_e});

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q      <= i_position;
            r_bsel   <= 1'b0;
            r_wait   <= '0;
            r_res    <= '0;
            r_drop   <= (t_mode'(i_mode) == MODE_INSERT) && w_full;
        end else if (r_state == ST_DIV && !r_bsel) begin
            r_bsel    <= 1'b1;
            r_trivial <= (r_count == '0) || !w_any || w_first[0];
            r_res     <= (r_count == '0) ? '0 : (w_any ? w_w1 : w_wlast);
            r_wa      <= w_w0;
            r_wb      <= w_w1;
            r_num     <= (DATA_W+1)'(r_q) - (DATA_W+1)'(w_p0);
            r_den     <= (DATA_W+1)'(w_p1) - (DATA_W+1)'(w_p0);
        end else if (r_state == ST_DIV && !r_wait[2]) begin
            r_wait <= r_wait + 3'd1;
        end else if (r_state == ST_EASE) begin
            r_ease <= w_sq;
        end else if (r_state == ST_MUL) begin
            r_res <= DATA_W'(r_wa + DATA_W'(w_prod >>> FRAC_W));
        end
    end

    // Count and running maximum follow the cell row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cmd.clr) begin
            r_count  <= '0;
            r_widest <= '0;
        end else if (w_cmd.ins) begin
            r_count <= r_count + CNT_W'(1);
            if (r_count == '0 || i_key_width > r_widest) begin
                r_widest <= i_key_width;
            end
        end
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = (r_state == ST_OUT);
    assign o_width_out   = r_res;
    assign o_max_width   = (r_count == '0) ? '0 : r_widest;
    assign o_entry_count = COUNT_W'(r_count);
    assign o_dropped     = r_drop;

endmodule
